[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define LSE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LSE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/lse_pkg.sv]
// ----------------------------------------------------------------------------
// lse_pkg
// Widths, codes and constant tables of the Legendre series evaluator.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int MAX_ORDER = 15;
    localparam int ORD_W     = 4;
    localparam int STORE_D   = MAX_ORDER + 1;
    localparam int DEG_W     = $clog2(STORE_D);

    localparam int COEF_W = 32;
    localparam int MU_W   = 32;
    localparam int SUM_W  = 48;

    // shared multiplier: A carries the recurrence numerator (37 bits signed)
    localparam int MUL_A_W = 37;
    localparam int MUL_B_W = 32;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_SCALE = 2'd1;
    localparam logic [1:0] CMD_EVAL  = 2'd2;

    localparam logic REG_SERIES_ORDER = 1'b0;

    localparam logic signed [MU_W-1:0] ONE_Q30     = 32'sh4000_0000;
    localparam logic signed [MU_W-1:0] NEG_ONE_Q30 = -32'sh4000_0000;

    // round(2^24 / l) for the recurrence step that produces degree l
    localparam logic [24:0] RECIP_Q24 [STORE_D] = '{
        25'd16777216, 25'd16777216, 25'd8388608, 25'd5592405,
        25'd4194304,  25'd3355443,  25'd2796203, 25'd2396745,
        25'd2097152,  25'd1864135,  25'd1677722, 25'd1525201,
        25'd1398101,  25'd1290555,  25'd1198373, 25'd1118481
    };

endpackage

[rtl/core/lse_mul.sv]
// ----------------------------------------------------------------------------
// lse_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module lse_mul (
    input  logic                                clk,
    input  logic signed [lse_pkg::MUL_A_W-1:0] op_a,
    input  logic signed [lse_pkg::MUL_B_W-1:0] op_b,
    output logic signed [lse_pkg::MUL_P_W-1:0] prod
);
    import lse_pkg::*;

    logic signed [MUL_P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
    end

    assign prod = prod_reg;

endmodule

[rtl/core/legendre_series_evaluator_top.sv]
// ----------------------------------------------------------------------------
// legendre_series_evaluator_top
// Legendre series evaluator: a 16-entry table of Q15.16 coefficients, a scale
// command and a series evaluation through the three-term recurrence, all on
// one shared multiplier under a small sequencer.
//
// A request is taken when start is high and busy is low. Every request gives
// exactly one result, shown on series_sum, index_error and saturated for one
// cycle while done is high; the receiver cannot stall, so sample on done.
// With N the order in use (series_order): a coefficient write or an unused
// command leaves busy low and shows its result in the next cycle; a scale
// holds busy while it rescales the N+1 table entries; an evaluation holds
// busy while it runs the recurrence up to degree N. The result shows in the
// first cycle after busy falls, and a new request may be taken in that same
// cycle. Busy time is set by the multiplier: each degree of the recurrence
// needs three products (mu*P, numerator*reciprocal, c*P) plus a step to form
// the numerator and a step to clamp the new P. series_order sits at byte
// address 0 of the APB port; writing a new value there clears the coefficient
// table, writing the same value does nothing. Configure only while idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module legendre_series_evaluator_top (
    input  logic                               clk,
    input  logic                               rst_n,
    // request channel
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         cmd,
    input  logic [lse_pkg::ORD_W-1:0]          coef_index,
    input  logic signed [lse_pkg::COEF_W-1:0]  coef_value,
    input  logic signed [lse_pkg::COEF_W-1:0]  scale_factor,
    input  logic signed [lse_pkg::MU_W-1:0]    cosine_mu,
    // result channel
    output logic                               done,
    output logic signed [lse_pkg::SUM_W-1:0]   series_sum,
    output logic                               index_error,
    output logic                               saturated,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [lse_pkg::APB_AW-1:0]         paddr,
    input  logic [lse_pkg::APB_DW-1:0]         pwdata,
    output logic [lse_pkg::APB_DW-1:0]         prdata,
    output logic                               pready
);
    import lse_pkg::*;

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SC_MUL = 4'd1;  // issue c*factor
    localparam logic [3:0] S_SC_WR  = 4'd2;  // round, clip, write back
    localparam logic [3:0] S_CP     = 4'd3;  // issue c*P
    localparam logic [3:0] S_ACC    = 4'd4;  // accumulate, issue mu*P
    localparam logic [3:0] S_NUM    = 4'd5;  // form recurrence numerator
    localparam logic [3:0] S_REC    = 4'd6;  // issue numerator*reciprocal
    localparam logic [3:0] S_NXT    = 4'd7;  // clamp new P, shift history
    localparam logic [3:0] S_FIN    = 4'd8;  // halve sum, present result

    localparam int NUM_W = MUL_A_W;
    localparam int CP_W  = COEF_W + 1;       // c*P/2^30 reaches 2^31
    localparam int WCP_W = CP_W + DEG_W + 2;
    localparam int ACC_W = WCP_W + DEG_W;    // room for STORE_D terms

    localparam logic signed [MUL_P_W-1:0] HALF16 = MUL_P_W'(1) <<< 15;
    localparam logic signed [MUL_P_W-1:0] HALF24 = MUL_P_W'(1) <<< 23;
    localparam logic signed [MUL_P_W-1:0] HALF30 = MUL_P_W'(1) <<< 29;
    localparam logic signed [MUL_P_W-1:0] P_ONE  = MUL_P_W'(ONE_Q30);
    localparam logic signed [MUL_P_W-1:0] P_NEG1 = MUL_P_W'(NEG_ONE_Q30);
    localparam logic signed [MUL_P_W-1:0] P_I32_MAX = MUL_P_W'(32'sh7FFF_FFFF);
    localparam logic signed [MUL_P_W-1:0] P_I32_MIN = -(MUL_P_W'(32'sh7FFF_FFFF)) - 1;

    // ---------------- control and datapath registers ----------------
    logic [3:0]                 state_reg, state_next;
    logic [DEG_W-1:0]           deg_reg, deg_next;
    logic [ORD_W-1:0]           series_order_reg;
    logic                       done_reg, done_next;

    logic signed [COEF_W-1:0]   opnd_reg, opnd_next;   // mu (clamped) or factor
    logic signed [MU_W-1:0]     cur_reg, cur_next;     // P_l
    logic signed [MU_W-1:0]     prev_reg, prev_next;   // P_{l-1}
    logic signed [NUM_W-1:0]    num_reg, num_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic                       sat_run_reg, sat_run_next;

    logic signed [SUM_W-1:0]    series_sum_reg, series_sum_next;
    logic                       index_error_reg, index_error_next;
    logic                       saturated_reg, saturated_next;

    // coefficient table
    logic signed [COEF_W-1:0]   coef_mem [STORE_D];
    logic                       wr_en;
    logic [DEG_W-1:0]           wr_idx;
    logic signed [COEF_W-1:0]   wr_data;
    logic signed [COEF_W-1:0]   coef_rd;

    // configuration
    logic                       cfg_wr;
    logic                       cfg_clear;
    logic [DEG_W-1:0]           ord_use;

    // shared multiplier
    logic signed [MUL_A_W-1:0]  mul_a;
    logic signed [MUL_B_W-1:0]  mul_b;
    logic signed [MUL_P_W-1:0]  prod;

    // product post-processing
    logic signed [MUL_P_W-1:0]  r16, r24, r30;
    logic                       sc_hit;
    logic signed [COEF_W-1:0]   sc_val;
    logic signed [MU_W-1:0]     p_new;
    logic signed [MU_W-1:0]     t_val;
    logic signed [CP_W-1:0]     cp_val;
    logic signed [WCP_W-1:0]    wcp;
    logic [DEG_W-1:0]           km1;
    logic signed [NUM_W:0]      num_a, num_b;
    logic signed [MU_W-1:0]     mu_clamped;
    logic signed [ACC_W-1:0]    acc_half;
    logic                       accept;

    // ---------------- APB ----------------
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready
                       && (paddr[2] == REG_SERIES_ORDER);
    assign cfg_clear = cfg_wr && (pwdata[ORD_W-1:0] != series_order_reg);
    assign prdata    = (paddr[2] == REG_SERIES_ORDER)
                       ? APB_DW'(series_order_reg) : '0;

    assign ord_use = (series_order_reg > ORD_W'(MAX_ORDER))
                     ? DEG_W'(MAX_ORDER) : DEG_W'(series_order_reg);

    // ---------------- handshake ----------------
    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;

    assign done        = done_reg;
    assign series_sum  = series_sum_reg;
    assign index_error = index_error_reg;
    assign saturated   = saturated_reg;

    // ---------------- coefficient table ----------------
    assign coef_rd = coef_mem[deg_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STORE_D; i++)
            begin
                coef_mem[i] <= '0;
            end
        end
        else if (cfg_clear)
        begin
            for (int i = 0; i < STORE_D; i++)
            begin
                coef_mem[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            coef_mem[wr_idx] <= wr_data;
        end
    end

    // ---------------- multiplier operand select ----------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SC_MUL:
            begin
                mul_a = MUL_A_W'(coef_rd);
                mul_b = MUL_B_W'(opnd_reg);
            end
            S_CP:
            begin
                mul_a = MUL_A_W'(coef_rd);
                mul_b = MUL_B_W'(cur_reg);
            end
            S_ACC:
            begin
                mul_a = MUL_A_W'(opnd_reg);
                mul_b = MUL_B_W'(cur_reg);
            end
            S_REC:
            begin
                mul_a = num_reg;
                mul_b = $signed(MUL_B_W'(RECIP_Q24[deg_reg]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    lse_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (prod)
    );

    // ---------------- rounding (half toward +inf) ----------------
    assign r16 = (prod + HALF16) >>> 16;
    assign r24 = (prod + HALF24) >>> 24;
    assign r30 = (prod + HALF30) >>> 30;

    // scaled coefficient, clipped to 32 bits
    always_comb
    begin
        sc_hit = 1'b0;
        sc_val = r16[COEF_W-1:0];
        if (r16 > P_I32_MAX)
        begin
            sc_hit = 1'b1;
            sc_val = 32'sh7FFF_FFFF;
        end
        else if (r16 < P_I32_MIN)
        begin
            sc_hit = 1'b1;
            sc_val = 32'sh8000_0000;
        end
    end

    // new P from the recurrence, bounded to [-1, 1]
    always_comb
    begin
        if (r24 > P_ONE)
        begin
            p_new = ONE_Q30;
        end
        else if (r24 < P_NEG1)
        begin
            p_new = NEG_ONE_Q30;
        end
        else
        begin
            p_new = r24[MU_W-1:0];
        end
    end

    assign t_val  = r30[MU_W-1:0];
    assign cp_val = r30[CP_W-1:0];
    assign wcp    = WCP_W'(cp_val) * $signed({2'b00, deg_reg, 1'b1});

    // numerator (2l-1)*t - (l-1)*P_{l-2}, l = deg_reg
    assign km1   = deg_reg - DEG_W'(1);
    assign num_a = (NUM_W + 1)'(t_val) * $signed({1'b0, km1, 1'b1});
    assign num_b = (NUM_W + 1)'(prev_reg) * $signed({1'b0, km1});

    assign mu_clamped = (cosine_mu > ONE_Q30)     ? ONE_Q30
                      : (cosine_mu < NEG_ONE_Q30) ? NEG_ONE_Q30
                      : cosine_mu;

    // |acc| < 2^40, so the halved sum always fits 48 bits: no clipping here
    assign acc_half = (acc_reg + ACC_W'(1)) >>> 1;

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next       = state_reg;
        deg_next         = deg_reg;
        done_next        = 1'b0;
        opnd_next        = opnd_reg;
        cur_next         = cur_reg;
        prev_next        = prev_reg;
        num_next         = num_reg;
        acc_next         = acc_reg;
        sat_run_next     = sat_run_reg;
        series_sum_next  = series_sum_reg;
        index_error_next = index_error_reg;
        saturated_next   = saturated_reg;
        wr_en            = 1'b0;
        wr_idx           = deg_reg;
        wr_data          = sc_val;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_WRITE:
                        begin
                            done_next        = 1'b1;
                            series_sum_next  = '0;
                            saturated_next   = 1'b0;
                            index_error_next = (DEG_W'(coef_index) > ord_use);
                            wr_en            = (DEG_W'(coef_index) <= ord_use);
                            wr_idx           = DEG_W'(coef_index);
                            wr_data          = coef_value;
                        end
                        CMD_SCALE:
                        begin
                            opnd_next    = scale_factor;
                            deg_next     = '0;
                            sat_run_next = 1'b0;
                            state_next   = S_SC_MUL;
                        end
                        CMD_EVAL:
                        begin
                            opnd_next  = mu_clamped;
                            deg_next   = '0;
                            acc_next   = '0;
                            cur_next   = ONE_Q30;
                            prev_next  = ONE_Q30;
                            state_next = S_CP;
                        end
                        default:
                        begin
                            // unused command: no effect, all-zero result
                            done_next        = 1'b1;
                            series_sum_next  = '0;
                            index_error_next = 1'b0;
                            saturated_next   = 1'b0;
                        end
                    endcase
                end
            end

            S_SC_MUL:
            begin
                state_next = S_SC_WR;
            end

            S_SC_WR:
            begin
                wr_en        = 1'b1;
                wr_idx       = deg_reg;
                wr_data      = sc_val;
                sat_run_next = sat_run_reg | sc_hit;
                if (deg_reg == ord_use)
                begin
                    done_next        = 1'b1;
                    series_sum_next  = '0;
                    index_error_next = 1'b0;
                    saturated_next   = sat_run_reg | sc_hit;
                    state_next       = S_IDLE;
                end
                else
                begin
                    deg_next   = deg_reg + DEG_W'(1);
                    state_next = S_SC_MUL;
                end
            end

            S_CP:
            begin
                state_next = S_ACC;
            end

            S_ACC:
            begin
                acc_next = acc_reg + ACC_W'(wcp);
                if (deg_reg == ord_use)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    deg_next = deg_reg + DEG_W'(1);
                    if (deg_reg == '0)
                    begin
                        // P_1 = mu, no recurrence step
                        prev_next  = ONE_Q30;
                        cur_next   = opnd_reg;
                        state_next = S_CP;
                    end
                    else
                    begin
                        state_next = S_NUM;
                    end
                end
            end

            S_NUM:
            begin
                // |numerator| < 2^36, fits NUM_W signed
                num_next   = NUM_W'(num_a - num_b);
                state_next = S_REC;
            end

            S_REC:
            begin
                state_next = S_NXT;
            end

            S_NXT:
            begin
                prev_next  = cur_reg;
                cur_next   = p_new;
                state_next = S_CP;
            end

            S_FIN:
            begin
                done_next        = 1'b1;
                series_sum_next  = SUM_W'(acc_half);
                index_error_next = 1'b0;
                saturated_next   = 1'b0;
                state_next       = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            deg_reg          <= '0;
            done_reg         <= 1'b0;
            series_order_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            deg_reg   <= deg_next;
            done_reg  <= done_next;
            if (cfg_wr)
            begin
                series_order_reg <= pwdata[ORD_W-1:0];
            end
        end
    end

    // datapath and result registers
    always_ff @(posedge clk)
    begin
        opnd_reg        <= opnd_next;
        cur_reg         <= cur_next;
        prev_reg        <= prev_next;
        num_reg         <= num_next;
        acc_reg         <= acc_next;
        sat_run_reg     <= sat_run_next;
        series_sum_reg  <= series_sum_next;
        index_error_reg <= index_error_next;
        saturated_reg   <= saturated_next;
    end

    // ---------------- assertions ----------------
    `LSE_ASSERT_IMPL(a_flags_excl, done_reg, !(index_error_reg && saturated_reg), "index_error and saturated together")
    `LSE_ASSERT_IMPL(a_ierr_sum_zero, done_reg && index_error_reg, series_sum_reg == '0, "nonzero sum on index error")
    `LSE_ASSERT_NEXT(a_long_cmd_busy, accept && (cmd == CMD_SCALE || cmd == CMD_EVAL), state_reg != S_IDLE, "scale or evaluate did not go busy")
    `LSE_ASSERT_IMPL(a_deg_bound, state_reg != S_IDLE, deg_reg <= ord_use, "degree counter past order")
    `LSE_ASSERT_IMPL(a_done_idle, done_reg, state_reg == S_IDLE, "result shown while sequencer busy")

endmodule

[verif/tb_legendre_series_evaluator_top.sv]
// ----------------------------------------------------------------------------
// tb_legendre_series_evaluator_top
// Self-checking bench for the Legendre series evaluator. Requests go in on
// the start/busy handshake and an in-bench predictor tracks the coefficient
// table and the order register, working out each result. Results are
// checked on done, field by field, in order. series_order is set over the
// APB port between phases, extremes included, and read back each time.
// ----------------------------------------------------------------------------
module tb_legendre_series_evaluator_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lse_pkg::*;

    // cmd value the block does not implement: no effect, all-zero result
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // register i sits at byte address 4*i; index 1 is not implemented
    localparam logic [APB_AW-1:0] ORDER_ADDR = {REG_SERIES_ORDER, 2'b00};
    localparam logic [APB_AW-1:0] SPARE_ADDR = 3'd4;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 125;
    // covers the longest evaluation, at the top order, and its result
    localparam int DRAIN_CYCLES    = 90;
    localparam int CYCLE_LIMIT     = 1_000_000;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic                    index_error;
        logic                    saturated;
    } series_result_t;

    // ------------------------------------------------------------------------
    // Predictor and scoreboard: holds its own copy of the order register and
    // the coefficient table, and a FIFO of the results still owed.
    // ------------------------------------------------------------------------
    class legendre_checker;
        logic [ORD_W-1:0]         order_q;
        logic signed [COEF_W-1:0] coef_store [STORE_D];
        series_result_t           owed_results [$];
        int unsigned              mismatches;
        int unsigned              results_checked;
        int unsigned              evals_noted;
        int unsigned              scales_noted;
        int unsigned              sat_results;
        int unsigned              index_errors;

        function new();
            order_q = '0;
            foreach (coef_store[i]) coef_store[i] = '0;
            mismatches      = 0;
            results_checked = 0;
            evals_noted     = 0;
            scales_noted    = 0;
            sat_results     = 0;
            index_errors    = 0;
        endfunction

        // a new order clears the table, the same order leaves it alone
        function void set_order(logic [ORD_W-1:0] value);
            if (value != order_q) begin
                order_q = value;
                foreach (coef_store[i]) coef_store[i] = '0;
            end
        endfunction

        // divide by 2^sh, rounding half toward +inf
        function longint round_half_up(longint v, int sh);
            return (v + (longint'(1) <<< (sh - 1))) >>> sh;
        endfunction

        function void note_request(logic [1:0] op, logic [ORD_W-1:0] idx,
                                   logic signed [COEF_W-1:0] coef,
                                   logic signed [COEF_W-1:0] factor,
                                   logic signed [MU_W-1:0] mu);
            series_result_t r;
            longint one_q30, m, prev, cur, acc, t, num, nxt, cp, p, k, recip;
            longint sum_max, sum_min;
            r       = '0;
            one_q30 = longint'(ONE_Q30);
            sum_max = (longint'(1) <<< (SUM_W - 1)) - 1;
            sum_min = -(longint'(1) <<< (SUM_W - 1));
            case (op)
                CMD_WRITE: begin
                    if (idx > order_q)
                        r.index_error = 1'b1;
                    else
                        coef_store[idx] = coef;
                end
                CMD_SCALE: begin
                    scales_noted++;
                    for (int d = 0; d <= order_q; d++) begin
                        p = round_half_up(longint'(coef_store[d]) * longint'(factor), 16);
                        if (p > 64'sd2147483647) begin
                            p = 64'sd2147483647;
                            r.saturated = 1'b1;
                        end else if (p < -64'sd2147483648) begin
                            p = -64'sd2147483648;
                            r.saturated = 1'b1;
                        end
                        coef_store[d] = p[COEF_W-1:0];
                    end
                end
                CMD_EVAL: begin
                    evals_noted++;
                    m = longint'(mu);
                    if (m > one_q30) m = one_q30;
                    else if (m < -one_q30) m = -one_q30;
                    prev = one_q30;
                    cur  = one_q30;
                    acc  = 0;
                    for (int d = 0; d <= order_q; d++) begin
                        if (d == 1) begin
                            prev = one_q30;
                            cur  = m;
                        end else if (d >= 2) begin
                            // P_d = ((2k+1) mu P_k - k P_{k-1}) * recip(d), k = d-1
                            k     = d - 1;
                            recip = ((longint'(1) <<< 25) / d + 1) >>> 1;
                            t     = round_half_up(m * cur, 30);
                            num   = (2 * k + 1) * t - k * prev;
                            nxt   = round_half_up(num * recip, 24);
                            prev  = cur;
                            if (nxt > one_q30) cur = one_q30;
                            else if (nxt < -one_q30) cur = -one_q30;
                            else cur = nxt;
                        end
                        cp  = round_half_up(longint'(coef_store[d]) * cur, 30);
                        acc = acc + longint'(2 * d + 1) * cp;
                    end
                    acc = round_half_up(acc, 1);
                    if (acc > sum_max) begin
                        acc = sum_max;
                        r.saturated = 1'b1;
                    end else if (acc < sum_min) begin
                        acc = sum_min;
                        r.saturated = 1'b1;
                    end
                    r.sum = acc[SUM_W-1:0];
                end
                default: ;
            endcase
            owed_results.push_back(r);
        endfunction

        function void check_result(logic signed [SUM_W-1:0] sum, logic ierr,
                                   logic sat);
            series_result_t r;
            if (owed_results.size() == 0) begin
                $display("%0t: unexpected result: series_sum %0d index_error %0b saturated %0b",
                         $time, sum, ierr, sat);
                mismatches++;
                return;
            end
            r = owed_results.pop_front();
            results_checked++;
            if (r.saturated) sat_results++;
            if (r.index_error) index_errors++;
            if (sum !== r.sum) begin
                $display("%0t: series_sum mismatch: expected %0d, actual %0d",
                         $time, r.sum, sum);
                mismatches++;
            end
            if (ierr !== r.index_error) begin
                $display("%0t: index_error mismatch: expected %0b, actual %0b",
                         $time, r.index_error, ierr);
                mismatches++;
            end
            if (sat !== r.saturated) begin
                $display("%0t: saturated mismatch: expected %0b, actual %0b",
                         $time, r.saturated, sat);
                mismatches++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [1:0]               cmd;
    logic [ORD_W-1:0]         coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic signed [COEF_W-1:0] scale_factor;
    logic signed [MU_W-1:0]   cosine_mu;
    logic                     done;
    logic signed [SUM_W-1:0]  series_sum;
    logic                     index_error;
    logic                     saturated;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_AW-1:0]        paddr;
    logic [APB_DW-1:0]        pwdata;
    logic [APB_DW-1:0]        prdata;
    logic                     pready;

    legendre_checker series_sb;
    int unsigned     requests_sent;
    int unsigned     orders_set;
    int unsigned     cycle_count;

    legendre_series_evaluator_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .coef_index   (coef_index),
        .coef_value   (coef_value),
        .scale_factor (scale_factor),
        .cosine_mu    (cosine_mu),
        .done         (done),
        .series_sum   (series_sum),
        .index_error  (index_error),
        .saturated    (saturated),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog: any hang lands here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Results can't be held off, so every done pulse is checked at the edge
    // that ends it.
    always @(posedge clk) begin
        if (rst_n && done)
            series_sb.check_result(series_sum, index_error, saturated);
    end

    // One request: fields change at the falling edge, then hold until a
    // rising edge sees busy low. start stays high afterwards so that
    // back-to-back requests need no extra assignment.
    task automatic send_request(input logic [1:0] op, input logic [ORD_W-1:0] idx,
                                input logic signed [COEF_W-1:0] coef,
                                input logic signed [COEF_W-1:0] factor,
                                input logic signed [MU_W-1:0] mu);
        @(negedge clk);
        start        <= 1'b1;
        cmd          <= op;
        coef_index   <= idx;
        coef_value   <= coef;
        scale_factor <= factor;
        cosine_mu    <= mu;
        do @(posedge clk); while (busy);
        series_sb.note_request(op, idx, coef, factor, mu);
        requests_sent++;
    endtask

    // Sender gap, start held low, with the given chance, in percent.
    task automatic idle_burst(input int gap_pct);
        int n;
        if ($urandom_range(0, 99) < gap_pct) begin
            n = $urandom_range(1, 18);
            @(negedge clk);
            start <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Drop start, let every owed result arrive, then give the block its
    // longest latency before anything touches the config port.
    task automatic wait_drained();
        @(negedge clk);
        start <= 1'b0;
        while (series_sb.owed_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // APB write (setup + access), then read series_order back.
    task automatic write_register(input logic [APB_AW-1:0] addr,
                                  input logic [APB_DW-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ORDER_ADDR)
            series_sb.set_order(data[ORD_W-1:0]);
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ORDER_ADDR;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[ORD_W-1:0] !== series_sb.order_q) begin
            $display("%0t: series_order readback mismatch: expected %0d, actual %0d",
                     $time, series_sb.order_q, prdata[ORD_W-1:0]);
            series_sb.mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Mostly moderate coefficients so that sums stay readable, some full range.
    function automatic logic signed [COEF_W-1:0] random_coef();
        logic signed [COEF_W-1:0] c;
        c = $urandom;
        if ($urandom_range(0, 9) < 7)
            c = c >>> $urandom_range(4, 20);
        return c;
    endfunction

    task automatic random_request(input int gap_pct);
        int                       sel;
        logic [1:0]               op;
        logic [ORD_W-1:0]         idx;
        logic signed [COEF_W-1:0] factor;
        logic signed [MU_W-1:0]   mu;
        sel = $urandom_range(0, 99);
        if (sel < 45)      op = CMD_WRITE;
        else if (sel < 55) op = CMD_SCALE;
        else if (sel < 95) op = CMD_EVAL;
        else               op = CMD_UNUSED;
        // mostly in range; the rest may land beyond the order
        if ($urandom_range(0, 99) < 85)
            idx = ORD_W'($urandom_range(0, series_sb.order_q));
        else
            idx = ORD_W'($urandom_range(0, 15));
        // scale factors near 1.0 keep the table alive; a few blow it up
        factor = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            factor = 32'sh0001_0000 + (factor >>> 20);
        else if (sel < 85)
            factor = factor >>> $urandom_range(12, 18);
        // mu mostly inside [-1,1], sometimes exactly on an end or far out
        mu  = $urandom;
        sel = $urandom_range(0, 99);
        if (sel < 75)      mu = mu >>> 1;
        else if (sel < 80) mu = ONE_Q30;
        else if (sel < 85) mu = NEG_ONE_Q30;
        idle_burst(gap_pct);
        send_request(op, idx, random_coef(), factor, mu);
    endtask

    initial begin
        int                       new_order;
        int                       gap_pct;
        int                       n;
        logic signed [COEF_W-1:0] c_max;
        logic signed [COEF_W-1:0] c_min;

        series_sb     = new();
        requests_sent = 0;
        orders_set    = 0;
        c_max         = 32'sh7FFF_FFFF;
        c_min         = 32'sh8000_0000;

        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = CMD_WRITE;
        coef_index   = '0;
        coef_value   = '0;
        scale_factor = '0;
        cosine_mu    = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = ORDER_ADDR;
        pwdata       = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // ---- directed part ----
        // Order 0 right after reset: empty table, then P_0 only.
        send_request(CMD_EVAL, 4'd0, 0, 0, ONE_Q30);
        send_request(CMD_WRITE, 4'd0, c_max, 0, 0);
        // index beyond the order: dropped and flagged
        send_request(CMD_WRITE, 4'd15, 32'sh0001_0000, 0, 0);
        send_request(CMD_EVAL, 4'd0, 0, 0, 0);

        // Order change to the top: table is cleared.
        wait_drained();
        write_register(ORDER_ADDR, 32'd15);
        orders_set++;
        send_request(CMD_EVAL, 4'd0, 0, 0, ONE_Q30);
        send_request(CMD_WRITE, 4'd0, c_min, 0, 0);
        send_request(CMD_WRITE, 4'd15, c_max, 0, 0);
        send_request(CMD_WRITE, 4'd7, 32'sh0001_0000, 0, 0);
        // mu extremes: both clamp, then the exact lower end and the middle
        send_request(CMD_EVAL, 4'd0, 0, 0, 32'sh7FFF_FFFF);
        send_request(CMD_EVAL, 4'd0, 0, 0, 32'sh8000_0000);
        send_request(CMD_EVAL, 4'd0, 0, 0, NEG_ONE_Q30);
        send_request(CMD_EVAL, 4'd0, 0, 0, 0);
        // scale extremes: clipping either way, then a wipe with zero
        send_request(CMD_SCALE, 4'd0, 0, c_max, 0);
        send_request(CMD_SCALE, 4'd0, 0, c_min, 0);
        send_request(CMD_EVAL, 4'd0, 0, 0, ONE_Q30);
        send_request(CMD_SCALE, 4'd0, 0, 0, 0);
        send_request(CMD_UNUSED, ORD_W'($urandom), $urandom, $urandom, $urandom);
        send_request(CMD_WRITE, 4'd3, 32'sh0001_0000, 0, 0);

        // Same order written again must keep the table; the unimplemented
        // register must change nothing.
        wait_drained();
        write_register(ORDER_ADDR, APB_DW'({$urandom, 4'd15}));
        write_register(SPARE_ADDR, $urandom);
        send_request(CMD_EVAL, 4'd0, 0, 0, ONE_Q30);
        send_request(CMD_EVAL, 4'd0, 0, 0, 32'sh2000_0000);

        // ---- random phases, one order setting each ----
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            wait_drained();
            case (phase)
                0:       new_order = 0;
                1:       new_order = 15;
                2:       new_order = 1;
                3:       new_order = 15;
                default: new_order = $urandom_range(0, 15);
            endcase
            write_register(ORDER_ADDR, APB_DW'({$urandom, 4'(new_order)}));
            orders_set++;
            // last phase runs without gaps
            if (phase == NUM_PHASES - 1)
                gap_pct = 0;
            else
                case ($urandom_range(0, 2))
                    0:       gap_pct = 0;
                    1:       gap_pct = 15;
                    default: gap_pct = 40;
                endcase
            n = 0;
            // usually a full table load first, so evaluations see real data
            if ($urandom_range(0, 3) != 0) begin
                for (int d = 0; d <= new_order; d++) begin
                    idle_burst(gap_pct);
                    send_request(CMD_WRITE, 4'(d), random_coef(), $urandom, $urandom);
                    n++;
                end
            end
            while (n < ITEMS_PER_PHASE) begin
                random_request(gap_pct);
                n++;
            end
        end

        wait_drained();

        $display("Ran %0d requests (%0d evaluations, %0d scales) over %0d order settings.",
                 requests_sent, series_sb.evals_noted, series_sb.scales_noted, orders_set);
        $display("Checked %0d results: %0d clipped, %0d index errors, %0d mismatches.",
                 series_sb.results_checked, series_sb.sat_results,
                 series_sb.index_errors, series_sb.mismatches);
        if (series_sb.mismatches == 0 && series_sb.owed_results.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
